### rtl/tca_pkg.sv
// Shared types, constants and the arctangent table of the tilt compensation unit.
package tca_pkg;

  // Angle and trig formats
  localparam int ANGLE_BITS   = 16;
  localparam int MAG_BITS     = 14;   // reduced magnitude, 0..9000 centidegrees
  localparam int TRIG_BITS    = 16;   // Q1.15 sine and cosine
  localparam int ATAN_ENTRIES = 24;
  localparam int CW           = 34;   // CORDIC x/y width, Q2.30 plus headroom
  localparam int ZW           = 32;   // CORDIC angle width, Q3.28
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]          CDEG_TO_RAD = 32'd3070415691;   // pi/18000 in Q44
  localparam logic signed [CW-1:0] TRIG_MAX    = 34'sd32767;

  // Register map, by word index
  typedef enum logic [1:0] {
    REG_BIAS_X = 2'd0,
    REG_BIAS_Y = 2'd1,
    REG_BIAS_Z = 2'd2
  } reg_idx_t;

  // Angle folded into the first quadrant with its sign corrections
  typedef struct packed {
    logic                neg;    // negate the sine
    logic                flip;   // negate the cosine
    logic [MAG_BITS-1:0] mag;    // centidegrees, 0..9000
  } angle_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 32'sd210828714;
      1:  r = 32'sd124459457;
      2:  r = 32'sd65760959;
      3:  r = 32'sd33381290;
      4:  r = 32'sd16755422;
      5:  r = 32'sd8385879;
      6:  r = 32'sd4193963;
      7:  r = 32'sd2097109;
      8:  r = 32'sd1048571;
      9:  r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/tca_if.sv
// Request channel interfaces: raw sample in, world-frame result out.
interface tca_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic signed [15:0]            roll_angle;
  logic signed [15:0]            pitch_angle;

  modport source(output valid, accel_x, accel_y, accel_z, roll_angle, pitch_angle,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, roll_angle, pitch_angle,
               output ready);
endinterface

interface tca_result_if #(parameter int OUT_BITS = 18);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] world_x;
  logic signed [OUT_BITS-1:0] world_y;

  modport source(output valid, world_x, world_y, input ready);
  modport sink(input valid, world_x, world_y, output ready);
endinterface

### rtl/tilt_compensated_accel_unit.sv
// Top level of the tilt compensation unit.
// Takes one raw accelerometer request per cycle while the queue is not full, with
// roll and pitch in centidegrees, removes the programmed biases and returns the two
// horizontal world-frame components, rounded. Sustained rate is one request per
// clock while the output is not held. The result path runs through the two parallel
// CORDIC pipelines (stage count capped at 24) and the three product stages. A
// four-entry queue sits between the input side and the processing pipeline; a result
// held at the output freezes the pipeline while the queue goes on taking up to four
// more requests. Bias registers sit at byte addresses 0, 4 and 8 and should be
// written only while the unit is idle.
module tilt_compensated_accel_unit #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  tca_sample_if.sink                 sample,
  tca_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tca_pkg::APB_AW-1:0] paddr,
  input  logic [tca_pkg::APB_DW-1:0] pwdata,
  output logic [tca_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int ITEM_W = 3 * (SAMPLE_BITS + 1) + 32;

  logic              q_push, q_pop, q_full, q_empty;
  logic [ITEM_W-1:0] q_din, q_head;

  assign pready = 1'b1;

  tca_front #(.SAMPLE_BITS(SAMPLE_BITS), .ITEM_W(ITEM_W)) u_front (
    .clk(clk), .rst(rst), .sample(sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .q_full(q_full), .q_push(q_push), .q_data(q_din)
  );

  tca_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  tca_back #(
    .CORDIC_STAGES(CORDIC_STAGES), .SAMPLE_BITS(SAMPLE_BITS), .ITEM_W(ITEM_W)
  ) u_back (
    .clk(clk), .rst(rst), .head(q_head), .empty(q_empty), .pop(q_pop),
    .result(result)
  );

endmodule

### rtl/tca_front.sv
// Front end: bias registers, request accept, bias removal and angle folding.
module tca_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int ITEM_W      = 3 * (SAMPLE_BITS + 1) + 32
) (
  input  logic                        clk,
  input  logic                        rst,
  tca_sample_if.sink                  sample,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tca_pkg::APB_AW-1:0]  paddr,
  input  logic [tca_pkg::APB_DW-1:0]  pwdata,
  output logic [tca_pkg::APB_DW-1:0]  prdata,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [ITEM_W-1:0]           q_data
);

  localparam int S1 = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] bias_x, bias_y, bias_z;
  logic signed [S1-1:0]          ax, ay, az;
  tca_pkg::angle_t               roll_c, pitch_c;
  logic                          wr;

  // Wrap into [-18000,18000], then fold into the first quadrant
  function automatic tca_pkg::angle_t fold(input logic signed [15:0] a);
    logic signed [16:0] w;
    logic [14:0]        m;
    tca_pkg::angle_t    r;
    w = 17'(a);
    if (w > 17'sd18000)       w = w - 17'sd36000;
    else if (w < -17'sd18000) w = w + 17'sd36000;
    r.neg  = w[16];
    m      = w[16] ? 15'(-w) : 15'(w);
    r.flip = m > 15'd9000;
    r.mag  = r.flip ? tca_pkg::MAG_BITS'(15'd18000 - m) : tca_pkg::MAG_BITS'(m);
    return r;
  endfunction

  // Register writes
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x <= '0;
      bias_y <= '0;
      bias_z <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        tca_pkg::REG_BIAS_X: bias_x <= pwdata[SAMPLE_BITS-1:0];
        tca_pkg::REG_BIAS_Y: bias_y <= pwdata[SAMPLE_BITS-1:0];
        tca_pkg::REG_BIAS_Z: bias_z <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads, sign extended
  always_comb begin
    case (paddr[3:2])
      tca_pkg::REG_BIAS_X: prdata = tca_pkg::APB_DW'(bias_x);
      tca_pkg::REG_BIAS_Y: prdata = tca_pkg::APB_DW'(bias_y);
      tca_pkg::REG_BIAS_Z: prdata = tca_pkg::APB_DW'(bias_z);
      default:             prdata = '0;
    endcase
  end

  // Remove the biases, fold the angles and hand the request to the queue
  always_comb begin
    ax      = S1'(sample.accel_x) - S1'(bias_x);
    ay      = S1'(sample.accel_y) - S1'(bias_y);
    az      = S1'(sample.accel_z) - S1'(bias_z);
    roll_c  = fold(sample.roll_angle);
    pitch_c = fold(sample.pitch_angle);
  end

  assign sample.ready = ~q_full;
  assign q_push       = sample.valid & ~q_full;
  assign q_data       = {ax, ay, az, roll_c, pitch_c};

endmodule

### rtl/tca_queue.sv
// Four-entry queue between front and back ends.
module tca_queue #(
  parameter int WIDTH = 83
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [4];
  logic [1:0]       wp, rp;
  logic [2:0]       cnt;

  assign full  = cnt == 3'd4;
  assign empty = cnt == 3'd0;
  assign head  = mem[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 3'd1;
        2'b01:   cnt <= cnt - 3'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/tca_cordic.sv
// Pipelined rotation-mode CORDIC giving Q1.15 sine and cosine of a folded angle.
module tca_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  tca_pkg::angle_t                      angle,
  output logic signed [tca_pkg::TRIG_BITS-1:0] sin_q,
  output logic signed [tca_pkg::TRIG_BITS-1:0] cos_q
);

  localparam int CW = tca_pkg::CW;
  localparam int ZW = tca_pkg::ZW;

  logic signed [CW-1:0] x [STAGES+1];
  logic signed [CW-1:0] y [STAGES+1];
  logic signed [ZW-1:0] z [STAGES+1];
  logic                 ng [STAGES+1];
  logic                 fl [STAGES+1];
  logic [45:0]          zprod;
  logic signed [CW-1:0] xr, yr, cc, ss;

  // Centidegrees to radians Q3.28, rounded
  assign zprod = 46'(angle.mag) * 46'(tca_pkg::CDEG_TO_RAD) + 46'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= tca_pkg::CORDIC_GAIN;
      y[0]  <= '0;
      z[0]  <= ZW'(zprod[45:16]);
      ng[0] <= angle.neg;
      fl[0] <= angle.flip;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - tca_pkg::atan_q28(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + tca_pkg::atan_q28(i);
        end
        ng[i+1] <= ng[i];
        fl[i+1] <= fl[i];
      end
    end
  end

  // Round to Q1.15, clamp, restore quadrant
  always_comb begin
    xr = (x[STAGES] + CW'(16384)) >>> 15;
    yr = (y[STAGES] + CW'(16384)) >>> 15;
    cc = xr > tca_pkg::TRIG_MAX ? tca_pkg::TRIG_MAX :
         xr < -tca_pkg::TRIG_MAX ? -tca_pkg::TRIG_MAX : xr;
    ss = yr > tca_pkg::TRIG_MAX ? tca_pkg::TRIG_MAX :
         yr < -tca_pkg::TRIG_MAX ? -tca_pkg::TRIG_MAX : yr;
    if (fl[STAGES]) cc = -cc;
    if (ng[STAGES]) ss = -ss;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= tca_pkg::TRIG_BITS'(cc);
      sin_q <= tca_pkg::TRIG_BITS'(ss);
    end
  end

endmodule

### rtl/tca_back.sv
// Back end: trig pipelines, rotation products, rounding and the output register.
module tca_back #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 16,
  parameter int ITEM_W        = 3 * (SAMPLE_BITS + 1) + 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ITEM_W-1:0] head,
  input  logic              empty,
  output logic              pop,
  tca_result_if.source      result
);

  localparam int NS = CORDIC_STAGES > tca_pkg::ATAN_ENTRIES ?
                      tca_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int LC = NS + 2;
  localparam int S1 = SAMPLE_BITS + 1;
  localparam int PW = S1 + tca_pkg::TRIG_BITS;
  localparam int OW = SAMPLE_BITS + 2;
  localparam int YW = PW + 2;
  localparam int XW = PW + 19;
  localparam int TB = tca_pkg::TRIG_BITS;

  logic                 adv;
  logic [LC-1:0]        vld;
  logic [3*S1-1:0]      dly [LC];
  tca_pkg::angle_t      roll_h, pitch_h;
  logic signed [TB-1:0] sr, cr, sp, cp;
  logic signed [S1-1:0] ax, ay, az;

  logic                 va, vb, vc;
  logic signed [PW-1:0] p_aycr, p_azsr, p_aysr, p_azcr;
  logic signed [S1-1:0] ax_a;
  logic signed [TB-1:0] sp_a, cp_a, sp_b;
  logic signed [YW-1:0] wy_b;
  logic signed [PW:0]   t_b;
  logic signed [PW-1:0] axcp_b, axcp_c;
  logic signed [PW+16:0] tsp_c;
  logic signed [OW-1:0] wy_c, wy_sat, wx_sat;
  logic signed [YW-1:0] wy_sh;
  logic signed [XW-1:0] wx_sum, wx_sh;

  // Whole back end moves when the output register can take a new result
  assign adv = ~result.valid | result.ready;
  assign pop = adv & ~empty;

  assign roll_h  = head[31:16];
  assign pitch_h = head[15:0];

  // Samples and valid bits travel alongside the trig pipelines
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LC-2:0], ~empty};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= head[ITEM_W-1:32];
      for (int k = 1; k < LC; k++) dly[k] <= dly[k-1];
    end
  end

  tca_cordic #(.STAGES(NS)) u_roll (
    .clk(clk), .en(adv), .angle(roll_h), .sin_q(sr), .cos_q(cr)
  );

  tca_cordic #(.STAGES(NS)) u_pitch (
    .clk(clk), .en(adv), .angle(pitch_h), .sin_q(sp), .cos_q(cp)
  );

  assign ax = dly[LC-1][3*S1-1:2*S1];
  assign ay = dly[LC-1][2*S1-1:S1];
  assign az = dly[LC-1][S1-1:0];

  // Stage A: roll products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_aycr <= ay * cr;
      p_azsr <= az * sr;
      p_aysr <= ay * sr;
      p_azcr <= az * cr;
      ax_a   <= ax;
      sp_a   <= sp;
      cp_a   <= cp;
    end
  end

  // Stage B: sums and the pitch cosine product
  always_ff @(posedge clk) begin
    if (adv) begin
      wy_b   <= YW'(p_aycr) - YW'(p_azsr) + YW'(16384);
      t_b    <= (PW+1)'(p_aysr) + (PW+1)'(p_azcr);
      axcp_b <= ax_a * cp_a;
      sp_b   <= sp_a;
    end
  end

  // Stage C: pitch sine product, world_y rounding
  always_comb begin
    wy_sh = wy_b >>> 15;
    if (wy_sh[YW-1:OW-1] != {(YW-OW+1){wy_sh[YW-1]}})
      wy_sat = wy_sh[YW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    else
      wy_sat = wy_sh[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tsp_c  <= (PW+17)'(t_b) * (PW+17)'(sp_b);
      axcp_c <= axcp_b;
      wy_c   <= wy_sat;
    end
  end

  // Final sum and world_x rounding
  always_comb begin
    wx_sum = (XW'(axcp_c) <<< 15) + XW'(tsp_c) + (XW'(1) <<< 29);
    wx_sh  = wx_sum >>> 30;
    if (wx_sh[XW-1:OW-1] != {(XW-OW+1){wx_sh[XW-1]}})
      wx_sat = wx_sh[XW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    else
      wx_sat = wx_sh[OW-1:0];
  end

  // Valid bits of the product stages and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      va           <= vld[LC-1];
      vb           <= va;
      vc           <= vb;
      result.valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.world_x <= wx_sat;
      result.world_y <= wy_c;
    end
  end

endmodule
